[rtl/core/point_line_distance_3d_core_assert.svh]
// Assertion macros shared by the distance core.
`ifndef POINT_LINE_DISTANCE_3D_CORE_ASSERT_SVH
`define POINT_LINE_DISTANCE_3D_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pld_pkg.sv]
package pld_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int MAG_W     = 2 * COORD_W + 1;
    localparam int LO_W      = 32;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int NUM_W     = SQ_W + 2;
    localparam int DEN_W     = 2 * COORD_W + 2;
    localparam int QUO_W     = 64;
    localparam int TOP_W     = NUM_W - QUO_W;
    localparam int DIST_W    = 32;
    localparam int SQRT_N    = QUO_W / 2;
    localparam int SREM_W    = DIST_W + 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_A_Z = 3'd2,
        REG_B_X = 3'd3,
        REG_B_Y = 3'd4,
        REG_B_Z = 3'd5
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [2:0][COORD_W-1:0] vec3_t;

    typedef struct packed {
        logic valid;
        logic degen;
        logic big;
    } flags_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              degen;
        logic              sat;
    } res_t;

endpackage

[rtl/core/pld_if.sv]
interface pld_query_if;
    logic                  valid;
    logic                  ready;
    logic signed [pld_pkg::COORD_W-1:0] query_x;
    logic signed [pld_pkg::COORD_W-1:0] query_y;
    logic signed [pld_pkg::COORD_W-1:0] query_z;

    modport source (output valid, output query_x, output query_y, output query_z, input ready);
    modport sink (input valid, input query_x, input query_y, input query_z, output ready);
endinterface

interface pld_result_if;
    logic                          valid;
    logic                          ready;
    logic [pld_pkg::DIST_W-1:0]    distance;
    logic                          line_degenerate;
    logic                          saturated;

    modport source (output valid, output distance, output line_degenerate, output saturated,
                    input ready);
    modport sink (input valid, input distance, input line_degenerate, input saturated,
                  output ready);
endinterface

[rtl/core/point_line_distance_3d_core.sv]
// Point to line distance core, signed Q16.16 coordinates.
// Pipeline: an accepted query beat passes 7 front stages, 64 divider cells, 32 square root
// cells and the output register on its way to its result beat.
// Throughput: one query beat per cycle while the skid buffer is empty, set by the fully pipelined cell chains.
// Reset: the line points clear to zero and the pipeline and output buffer empty.
`include "point_line_distance_3d_core_assert.svh"

module point_line_distance_3d_core (
    input  logic                          clk,
    input  logic                          rst_n,
    pld_query_if.sink                     query,
    pld_result_if.source                  result,
    input  logic                          cfg_wr_en,
    input  logic [pld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pld_pkg::COORD_W-1:0]   cfg_data
);
    import pld_pkg::*;

    coord_t cfg_reg [6];
    vec3_t  query_vec;
    vec3_t  point_a;
    vec3_t  point_b;
    logic   en;

    flags_t            div_flags [QUO_W+1];
    logic [DEN_W-1:0]  div_den   [QUO_W+1];
    logic [DEN_W-1:0]  div_rem   [QUO_W+1];
    logic [QUO_W-1:0]  div_quo   [QUO_W+1];

    flags_t            sq_flags [SQRT_N+1];
    logic [QUO_W-1:0]  sq_x     [SQRT_N+1];
    logic [SREM_W-1:0] sq_rem   [SQRT_N+1];
    logic [DIST_W-1:0] sq_root  [SQRT_N+1];

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    res_t res_in;
    logic res_in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_A_X: cfg_reg[REG_A_X] <= cfg_data;
                REG_A_Y: cfg_reg[REG_A_Y] <= cfg_data;
                REG_A_Z: cfg_reg[REG_A_Z] <= cfg_data;
                REG_B_X: cfg_reg[REG_B_X] <= cfg_data;
                REG_B_Y: cfg_reg[REG_B_Y] <= cfg_data;
                REG_B_Z: cfg_reg[REG_B_Z] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign query_vec = {query.query_z, query.query_y, query.query_x};
    assign point_a   = {cfg_reg[REG_A_Z], cfg_reg[REG_A_Y], cfg_reg[REG_A_X]};
    assign point_b   = {cfg_reg[REG_B_Z], cfg_reg[REG_B_Y], cfg_reg[REG_B_X]};

    assign en          = !skid_valid_reg;
    assign query.ready = en;

    pld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (query.valid),
        .query    (query_vec),
        .point_a  (point_a),
        .point_b  (point_b),
        .flags    (div_flags[0]),
        .den      (div_den[0]),
        .rem      (div_rem[0]),
        .quo      (div_quo[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        pld_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .flags_i (div_flags[i]),
            .den_i   (div_den[i]),
            .rem_i   (div_rem[i]),
            .quo_i   (div_quo[i]),
            .flags_o (div_flags[i+1]),
            .den_o   (div_den[i+1]),
            .rem_o   (div_rem[i+1]),
            .quo_o   (div_quo[i+1])
        );
    end

    assign sq_flags[0] = div_flags[QUO_W];
    assign sq_x[0]     = div_quo[QUO_W];
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqrt
        pld_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .flags_i (sq_flags[i]),
            .x_i     (sq_x[i]),
            .rem_i   (sq_rem[i]),
            .root_i  (sq_root[i]),
            .flags_o (sq_flags[i+1]),
            .x_o     (sq_x[i+1]),
            .rem_o   (sq_rem[i+1]),
            .root_o  (sq_root[i+1])
        );
    end

    always_comb
    begin
        res_in.distance = sq_flags[SQRT_N].big ? '1 : sq_root[SQRT_N];
        res_in.degen    = sq_flags[SQRT_N].degen;
        res_in.sat      = sq_flags[SQRT_N].big;
        res_in_valid    = sq_flags[SQRT_N].valid && en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_in_valid;
            end
        end
        else if (res_in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_in;
        end
        else if (res_in_valid)
        begin
            skid_reg <= res_in;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.distance        = out_reg.distance;
    assign result.line_degenerate = out_reg.degen;
    assign result.saturated       = out_reg.sat;

    `PLD_ASSERT_SAME(a_sat_clamps, result.valid && result.saturated, result.distance == '1, "saturated beat without clamped distance")
    `PLD_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid holds a beat while the output is empty")
    `PLD_ASSERT_NEXT(a_stall_to_skid, res_in_valid && result.valid && !result.ready, skid_valid_reg, "beat from the pipeline lost on output stall")

endmodule

[rtl/core/pld_front.sv]
module pld_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  pld_pkg::vec3_t                 query,
    input  pld_pkg::vec3_t                 point_a,
    input  pld_pkg::vec3_t                 point_b,
    output pld_pkg::flags_t                flags,
    output logic [pld_pkg::DEN_W-1:0]      den,
    output logic [pld_pkg::DEN_W-1:0]      rem,
    output logic [pld_pkg::QUO_W-1:0]      quo
);
    import pld_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] degen_reg;
    logic            degen_next;
    flags_t          flags_reg;
    flags_t          flags_next;

    logic signed [DIFF_W-1:0] d_next [3];
    logic signed [DIFF_W-1:0] w_next [3];
    logic signed [DIFF_W-1:0] s1_d_reg [3];
    logic signed [DIFF_W-1:0] s1_w_reg [3];

    logic signed [PROD_W-1:0] p_next [6];
    logic [PROD_W-1:0]        dd_next [3];
    logic signed [PROD_W-1:0] s2_p_reg [6];
    logic [PROD_W-1:0]        s2_dd_reg [3];
    logic signed [DIFF_W-1:0] s2_w_reg [3];

    logic [PROD_W:0]          diff [3];
    logic [PROD_W:0]          absd [3];
    logic [DIFF_W-1:0]        absw [3];
    logic [MAG_W-1:0]         mag_next [3];
    logic [DEN_W-1:0]         den3_next;
    logic [MAG_W-1:0]         s3_mag_reg [3];
    logic [DEN_W-1:0]         s3_den_reg;

    logic [2*HI_W-1:0]        hh_next [3];
    logic [HI_W+LO_W-1:0]     hl_next [3];
    logic [2*LO_W-1:0]        ll_next [3];
    logic [2*HI_W-1:0]        s4_hh_reg [3];
    logic [HI_W+LO_W-1:0]     s4_hl_reg [3];
    logic [2*LO_W-1:0]        s4_ll_reg [3];
    logic [DEN_W-1:0]         s4_den_reg;

    logic [SQ_W-1:0]          sq_next [3];
    logic [SQ_W-1:0]          s5_sq_reg [3];
    logic [DEN_W-1:0]         s5_den_reg;

    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         s6_num_reg;
    logic [DEN_W-1:0]         s6_den_reg;

    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         rem_next;
    logic [QUO_W-1:0]         quo_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = {point_a[k][COORD_W-1], point_a[k]} - {point_b[k][COORD_W-1], point_b[k]};
            w_next[k] = {query[k][COORD_W-1], query[k]} - {point_a[k][COORD_W-1], point_a[k]};
        end
        degen_next = (d_next[0] == '0) && (d_next[1] == '0) && (d_next[2] == '0);

        p_next[0] = s1_d_reg[1] * s1_w_reg[2];
        p_next[1] = s1_d_reg[2] * s1_w_reg[1];
        p_next[2] = s1_d_reg[2] * s1_w_reg[0];
        p_next[3] = s1_d_reg[0] * s1_w_reg[2];
        p_next[4] = s1_d_reg[0] * s1_w_reg[1];
        p_next[5] = s1_d_reg[1] * s1_w_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            dd_next[k] = s1_d_reg[k] * s1_d_reg[k];
        end

        for (int k = 0; k < 3; k++)
        begin
            diff[k] = {s2_p_reg[2*k][PROD_W-1], s2_p_reg[2*k]}
                    - {s2_p_reg[2*k+1][PROD_W-1], s2_p_reg[2*k+1]};
            absd[k] = diff[k][PROD_W] ? (~diff[k] + 1'b1) : diff[k];
            absw[k] = s2_w_reg[k][DIFF_W-1] ? (~s2_w_reg[k] + 1'b1) : s2_w_reg[k];
            mag_next[k] = degen_reg[1] ? MAG_W'(absw[k]) : absd[k][MAG_W-1:0];
        end
        den3_next = degen_reg[1] ? DEN_W'(1)
                  : DEN_W'(s2_dd_reg[0][2*COORD_W-1:0]) + DEN_W'(s2_dd_reg[1][2*COORD_W-1:0])
                  + DEN_W'(s2_dd_reg[2][2*COORD_W-1:0]);

        for (int k = 0; k < 3; k++)
        begin
            hh_next[k] = s3_mag_reg[k][MAG_W-1:LO_W] * s3_mag_reg[k][MAG_W-1:LO_W];
            hl_next[k] = s3_mag_reg[k][MAG_W-1:LO_W] * s3_mag_reg[k][LO_W-1:0];
            ll_next[k] = s3_mag_reg[k][LO_W-1:0] * s3_mag_reg[k][LO_W-1:0];
            sq_next[k] = (SQ_W'(s4_hh_reg[k]) << (2 * LO_W))
                       + (SQ_W'(s4_hl_reg[k]) << (LO_W + 1))
                       + SQ_W'(s4_ll_reg[k]);
        end

        num_next = NUM_W'(s5_sq_reg[0]) + NUM_W'(s5_sq_reg[1]) + NUM_W'(s5_sq_reg[2]);

        flags_next.valid = vld_reg[NSTG-1];
        flags_next.degen = degen_reg[NSTG-1];
        flags_next.big   = s6_num_reg[NUM_W-1:QUO_W] >= TOP_W'(s6_den_reg);
        rem_next = flags_next.big ? '0 : s6_num_reg[QUO_W +: DEN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            degen_reg <= '0;
            flags_reg <= '0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[NSTG-2:0], in_valid};
            degen_reg <= {degen_reg[NSTG-2:0], degen_next};
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_d_reg[k]   <= d_next[k];
                s1_w_reg[k]   <= w_next[k];
                s2_dd_reg[k]  <= dd_next[k];
                s2_w_reg[k]   <= s1_w_reg[k];
                s3_mag_reg[k] <= mag_next[k];
                s4_hh_reg[k]  <= hh_next[k];
                s4_hl_reg[k]  <= hl_next[k];
                s4_ll_reg[k]  <= ll_next[k];
                s5_sq_reg[k]  <= sq_next[k];
            end
            for (int k = 0; k < 6; k++)
            begin
                s2_p_reg[k] <= p_next[k];
            end
            s3_den_reg <= den3_next;
            s4_den_reg <= s3_den_reg;
            s5_den_reg <= s4_den_reg;
            s6_den_reg <= s5_den_reg;
            s6_num_reg <= num_next;
            den_reg    <= s6_den_reg;
            rem_reg    <= rem_next;
            quo_reg    <= s6_num_reg[QUO_W-1:0];
        end
    end

    assign flags = flags_reg;
    assign den   = den_reg;
    assign rem   = rem_reg;
    assign quo   = quo_reg;

endmodule

[rtl/core/pld_div_cell.sv]
module pld_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  pld_pkg::flags_t           flags_i,
    input  logic [pld_pkg::DEN_W-1:0] den_i,
    input  logic [pld_pkg::DEN_W-1:0] rem_i,
    input  logic [pld_pkg::QUO_W-1:0] quo_i,
    output pld_pkg::flags_t           flags_o,
    output logic [pld_pkg::DEN_W-1:0] den_o,
    output logic [pld_pkg::DEN_W-1:0] rem_o,
    output logic [pld_pkg::QUO_W-1:0] quo_o
);
    import pld_pkg::*;

    flags_t           flags_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   sub;
    logic [DEN_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_i, quo_i[QUO_W-1]};
        ge       = trial >= {1'b0, den_i};
        sub      = trial - {1'b0, den_i};
        rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_i[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (en)
        begin
            flags_reg <= flags_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_i;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign flags_o = flags_reg;
    assign den_o   = den_reg;
    assign rem_o   = rem_reg;
    assign quo_o   = quo_reg;

endmodule

[rtl/core/pld_sqrt_cell.sv]
module pld_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  pld_pkg::flags_t            flags_i,
    input  logic [pld_pkg::QUO_W-1:0]  x_i,
    input  logic [pld_pkg::SREM_W-1:0] rem_i,
    input  logic [pld_pkg::DIST_W-1:0] root_i,
    output pld_pkg::flags_t            flags_o,
    output logic [pld_pkg::QUO_W-1:0]  x_o,
    output logic [pld_pkg::SREM_W-1:0] rem_o,
    output logic [pld_pkg::DIST_W-1:0] root_o
);
    import pld_pkg::*;

    flags_t            flags_reg;
    logic [QUO_W-1:0]  x_reg;
    logic [SREM_W-1:0] rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] sub;
    logic              ge;
    logic [SREM_W-1:0] rem_next;
    logic [DIST_W-1:0] root_next;

    always_comb
    begin
        cur       = {rem_i, x_i[QUO_W-1 -: 2]};
        trial     = (SREM_W+2)'({root_i, 2'b01});
        ge        = cur >= trial;
        sub       = cur - trial;
        rem_next  = ge ? sub[SREM_W-1:0] : cur[SREM_W-1:0];
        root_next = {root_i[DIST_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (en)
        begin
            flags_reg <= flags_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= {x_i[QUO_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign flags_o = flags_reg;
    assign x_o     = x_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;

endmodule
